[sv/assert_macros.svh]
// Assertion helpers for the RTL; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[sv/tgarle_pkg.sv]
`default_nettype none

package tgarle_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RLE_MODE      = 3'd0;
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd1;
  localparam logic [2:0] REG_ALPHA_ENABLE  = 3'd2;
  localparam logic [2:0] REG_RIGHT_TO_LEFT = 3'd3;
  localparam logic [2:0] REG_SCAN_PIXELS   = 3'd4;

  // Pixel format codes (code 3 behaves as BGRA)
  localparam logic [1:0] FMT_555  = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  // Reset values of the configuration registers
  localparam logic        RST_RLE_MODE      = 1'b1;
  localparam logic [1:0]  RST_PIXEL_FORMAT  = FMT_BGR;
  localparam logic        RST_ALPHA_ENABLE  = 1'b0;
  localparam logic        RST_RIGHT_TO_LEFT = 1'b0;
  localparam logic [15:0] RST_SCAN_PIXELS   = 16'd640;

  // Packet header layout
  localparam int HDR_RUN_BIT = 7;
  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;

  typedef struct packed {
    logic [1:0] pixel_format;
    logic       alpha_enable;
  } color_cfg_t;

  // Premultiply one channel: t = c*a + 128, result (t + (t >> 8)) >> 8.
  function automatic logic [7:0] mul_alpha(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] t;
    logic [15:0] s;
    t = 16'(c * a) + 16'd128;
    s = t + {8'd0, t[15:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

[sv/tga_rle_line_decoder.sv]
`default_nettype none

`include "assert_macros.svh"

// TGA scanline decoder. Takes one encoded byte per item on the in_ channel and
// sustains one byte per clock while out_ is ready or stage 1 is empty. In
// run-length mode a header byte (bit 7 = repeat, low 7 bits + 1 = count) is
// consumed without a result; each completed pixel (2, 3 or 4 bytes by pixel_format)
// gives one result with its oriented x position, the pixels it covers (a whole
// repeat packet in one result), RGB color, line_done and run_clipped. Packets are
// clipped at the line end, never wrapped. The pipe has two stages: byte decode and
// line bookkeeping, then color conversion with the alpha multiply; a result moves
// from stage 1 into the output register, which lets the next byte in while a result
// waits. Write configuration through cfg_ only while no item is in flight.
module tga_rle_line_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_x_position,
  output logic [7:0]       out_run_length,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_line_done,
  output logic             out_run_clipped
);

  // Configuration registers
  logic        rle_mode_r;
  logic [1:0]  pixel_format_r;
  logic        alpha_enable_r;
  logic        right_to_left_r;
  logic [15:0] scan_pixels_r;

  // Decode state
  logic        expect_header_r, expect_header_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic [31:0] pixel_bytes_r, pixel_bytes_nxt;
  logic [7:0]  packet_remaining_r, packet_remaining_nxt;
  logic        packet_is_run_r, packet_is_run_nxt;
  logic [15:0] pixel_index_r, pixel_index_nxt;

  // Stage 1: a completed pixel awaiting color conversion
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_pixel_r;
  logic [15:0] s1_x_r, s1_x_nxt;
  logic [7:0]  s1_len_r, s1_len_nxt;
  logic        s1_done_r, s1_done_nxt;
  logic        s1_clip_r, s1_clip_nxt;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_x_r;
  logic [7:0]  out_len_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;
  logic        out_done_r, out_clip_r;

  logic        out_adv;
  logic        s1_adv;
  logic        in_acc;
  logic        emit;

  tgarle_pkg::color_cfg_t color_cfg;
  logic [7:0]  conv_red, conv_green, conv_blue;

  // Handshake: the output register frees when empty or taken; stage 1 moves on then.
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_acc   = in_valid && in_ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r      <= tgarle_pkg::RST_RLE_MODE;
      pixel_format_r  <= tgarle_pkg::RST_PIXEL_FORMAT;
      alpha_enable_r  <= tgarle_pkg::RST_ALPHA_ENABLE;
      right_to_left_r <= tgarle_pkg::RST_RIGHT_TO_LEFT;
      scan_pixels_r   <= tgarle_pkg::RST_SCAN_PIXELS;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::REG_RLE_MODE:      rle_mode_r      <= cfg_data[0];
        tgarle_pkg::REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_data[1:0];
        tgarle_pkg::REG_ALPHA_ENABLE:  alpha_enable_r  <= cfg_data[0];
        tgarle_pkg::REG_RIGHT_TO_LEFT: right_to_left_r <= cfg_data[0];
        tgarle_pkg::REG_SCAN_PIXELS:   scan_pixels_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte decode and line bookkeeping
  always_comb begin
    logic [16:0] w17;
    logic [15:0] pi_eff;
    logic [2:0]  need;
    logic        take_hdr;
    logic        byte_done;
    logic [31:0] merged;
    logic [16:0] left;
    logic [7:0]  rem_dec;
    logic        run_path;
    logic        run_clip;
    logic        lit_clip;
    logic [16:0] next17;
    logic [16:0] xm17;

    // Width zero stands for 65536 pixels.
    w17 = (scan_pixels_r == 16'd0) ? 17'h10000 : {1'b0, scan_pixels_r};
    // Restart the index if the width shrank under it.
    pi_eff = ({1'b0, pixel_index_r} >= w17) ? 16'd0 : pixel_index_r;

    case (pixel_format_r)
      tgarle_pkg::FMT_555: need = 3'd2;
      tgarle_pkg::FMT_BGR: need = 3'd3;
      default:             need = 3'd4;
    endcase

    take_hdr  = rle_mode_r && (expect_header_r || packet_remaining_r == 8'd0);
    byte_done = ({1'b0, byte_index_r} + 3'd1) >= need;

    // The first byte of a pixel clears the older bytes.
    case (byte_index_r)
      2'd0:    merged = {24'd0, in_data_byte};
      2'd1:    merged = {pixel_bytes_r[31:16], in_data_byte, pixel_bytes_r[7:0]};
      2'd2:    merged = {pixel_bytes_r[31:24], in_data_byte, pixel_bytes_r[15:0]};
      default: merged = {in_data_byte, pixel_bytes_r[23:0]};
    endcase

    left     = w17 - {1'b0, pi_eff};
    rem_dec  = packet_remaining_r - 8'd1;
    run_path = rle_mode_r && packet_is_run_r;
    run_clip = {9'd0, packet_remaining_r} > left;
    lit_clip = rle_mode_r && (left == 17'd1) && (rem_dec != 8'd0);

    if (run_path) begin
      s1_len_nxt  = run_clip ? left[7:0] : packet_remaining_r;
      s1_clip_nxt = run_clip;
    end else begin
      s1_len_nxt  = 8'd1;
      s1_clip_nxt = lit_clip;
    end

    next17      = {1'b0, pi_eff} + {9'd0, s1_len_nxt};
    s1_done_nxt = next17 >= w17;
    xm17        = w17 - 17'd1 - {1'b0, pi_eff};
    s1_x_nxt    = right_to_left_r ? xm17[15:0] : pi_eff;

    expect_header_nxt    = expect_header_r;
    byte_index_nxt       = byte_index_r;
    pixel_bytes_nxt      = pixel_bytes_r;
    packet_remaining_nxt = packet_remaining_r;
    packet_is_run_nxt    = packet_is_run_r;
    pixel_index_nxt      = pixel_index_r;
    emit                 = 1'b0;

    if (in_acc) begin
      pixel_index_nxt = pi_eff;
      if (take_hdr) begin
        // Header byte: open a packet, no result.
        packet_is_run_nxt    = in_data_byte[tgarle_pkg::HDR_RUN_BIT];
        packet_remaining_nxt = {1'b0, in_data_byte[6:0] & tgarle_pkg::HDR_COUNT_MASK} + 8'd1;
        expect_header_nxt    = 1'b0;
        byte_index_nxt       = 2'd0;
      end else begin
        pixel_bytes_nxt = merged;
        if (!byte_done) begin
          byte_index_nxt = byte_index_r + 2'd1;
        end else begin
          byte_index_nxt = 2'd0;
          emit           = 1'b1;
          if (run_path) begin
            packet_remaining_nxt = 8'd0;
            expect_header_nxt    = 1'b1;
          end else if (rle_mode_r) begin
            // Drop the rest of a literal packet that overruns the line.
            packet_remaining_nxt = lit_clip ? 8'd0 : rem_dec;
            if (lit_clip || rem_dec == 8'd0) begin
              expect_header_nxt = 1'b1;
            end
          end
          pixel_index_nxt = s1_done_nxt ? 16'd0 : next17[15:0];
        end
      end
    end

    if (emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r    <= 1'b1;
      byte_index_r       <= 2'd0;
      pixel_bytes_r      <= 32'd0;
      packet_remaining_r <= 8'd0;
      packet_is_run_r    <= 1'b0;
      pixel_index_r      <= 16'd0;
      s1_valid_r         <= 1'b0;
    end else begin
      expect_header_r    <= expect_header_nxt;
      byte_index_r       <= byte_index_nxt;
      pixel_bytes_r      <= pixel_bytes_nxt;
      packet_remaining_r <= packet_remaining_nxt;
      packet_is_run_r    <= packet_is_run_nxt;
      pixel_index_r      <= pixel_index_nxt;
      s1_valid_r         <= s1_valid_nxt;
    end
  end

  // Stage 1 payload: load on each completed pixel.
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_pixel_r <= pixel_bytes_nxt;
      s1_x_r     <= s1_x_nxt;
      s1_len_r   <= s1_len_nxt;
      s1_done_r  <= s1_done_nxt;
      s1_clip_r  <= s1_clip_nxt;
    end
  end

  // Stage 2: color conversion into the output register
  assign color_cfg.pixel_format = pixel_format_r;
  assign color_cfg.alpha_enable = alpha_enable_r;

  tgarle_color u_color (
    .pixel_bytes (s1_pixel_r),
    .cfg         (color_cfg),
    .red         (conv_red),
    .green       (conv_green),
    .blue        (conv_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_x_r     <= s1_x_r;
      out_len_r   <= s1_len_r;
      out_red_r   <= conv_red;
      out_green_r <= conv_green;
      out_blue_r  <= conv_blue;
      out_done_r  <= s1_done_r;
      out_clip_r  <= s1_clip_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_position  = out_x_r;
  assign out_run_length  = out_len_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_line_done   = out_done_r;
  assign out_run_clipped = out_clip_r;

  // A clipped packet always reaches the line end.
  `ASSERT_IMPL(a_clip_ends_line, out_valid_r && out_clip_r, out_done_r)
  // Every pixel result covers 1 to 128 pixels.
  `ASSERT_IMPL(a_len_range, s1_valid_r, s1_len_r != 8'd0 && s1_len_r <= 8'd128)
  // A pixel leaving stage 1 lands in the output register.
  `ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_r)
  // A header byte never yields a pixel.
  `ASSERT_NEXT(a_hdr_no_pixel, in_acc && rle_mode_r && expect_header_r && !s1_valid_r,
               !s1_valid_r)

endmodule

`default_nettype wire

[sv/tgarle_color.sv]
`default_nettype none

// Turn the assembled pixel bytes into RGB, with optional alpha premultiply.
module tgarle_color (
  input  wire logic [31:0]            pixel_bytes,
  input  wire tgarle_pkg::color_cfg_t cfg,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue
);

  always_comb begin
    case (cfg.pixel_format)
      tgarle_pkg::FMT_555: begin
        // 555 little endian, bit 15 dropped
        blue  = {pixel_bytes[4:0], 3'b000};
        green = {pixel_bytes[9:5], 3'b000};
        red   = {pixel_bytes[14:10], 3'b000};
      end
      tgarle_pkg::FMT_BGR: begin
        blue  = pixel_bytes[7:0];
        green = pixel_bytes[15:8];
        red   = pixel_bytes[23:16];
      end
      default: begin
        if (cfg.alpha_enable) begin
          blue  = tgarle_pkg::mul_alpha(pixel_bytes[7:0], pixel_bytes[31:24]);
          green = tgarle_pkg::mul_alpha(pixel_bytes[15:8], pixel_bytes[31:24]);
          red   = tgarle_pkg::mul_alpha(pixel_bytes[23:16], pixel_bytes[31:24]);
        end else begin
          blue  = pixel_bytes[7:0];
          green = pixel_bytes[15:8];
          red   = pixel_bytes[23:16];
        end
      end
    endcase
  end

endmodule

`default_nettype wire
